FILE: hdl/ttsd_pkg.sv
// Tick task slot dispatcher: shared types and codes.
// Holds command codes, reply kinds, controller states and the
// command and status bundles between controller and datapath.
package ttsd_pkg;

  typedef enum logic [2:0] {
    CMD_REGISTER   = 3'd0,
    CMD_ENABLE     = 3'd1,
    CMD_DISABLE    = 3'd2,
    CMD_UNREGISTER = 3'd3,
    CMD_TICK       = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    RK_REGISTER = 2'd0,
    RK_ACK      = 2'd1,
    RK_DISPATCH = 2'd2
  } reply_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG,
    S_MOD,
    S_TRIM,
    S_TICK
  } state_t;

  localparam logic [3:0] MAX_DISPATCH = 4'd8;

  typedef struct packed {
    logic load;
    logic reg_fail;
    logic reg_write;
    logic reg_advance;
    logic mod_apply;
    logic trim_step;
    logic tick_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic handle_zero;
    logic idx_end;
    logic slot_free;
    logic unreg_top;
    logic trim_done;
    logic tick_done;
  } dp_sts_t;

endpackage

FILE: hdl/tick_task_slot_dispatcher.sv
// Tick task slot dispatcher: top level joining controller and datapath.
// Depends on ttsd_pkg, ttsd_ctrl and ttsd_dpath.
//
// Usage:
//   A request is taken at a clock edge where start is high and busy is low.
//   in_command selects register, enable, disable, unregister or tick; the
//   slot and handle ports carry its operands. Unknown commands are dropped.
//   Results appear on the out_ ports for one cycle each, flagged by
//   out_valid; the receiver cannot stall, so every flagged cycle is taken.
//   Sequencing:
//   - register: the free-slot search steps one slot a cycle; the reply is
//     issued when a free slot is found or the search fails.
//   - enable/disable: the slot bits are updated and acknowledged together.
//   - unregister of the top scanned slot: acknowledge, then stay busy while
//     the scan limit is trimmed one slot a cycle down to an occupied slot.
//   - tick: the scan visits one slot a cycle up to the scan limit (or eight
//     hits); each hit is read into the read register, then waits in the hold
//     register until the next hit is read or the scan ends, then goes out.
//   busy stays high until the final result is issued or the scan ends.
//   Reset empties every slot, clears all enables and the scan limit.
module tick_task_slot_dispatcher #(
  parameter int SLOT_COUNT  = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_slot_id,
  input  logic [15:0] in_task_handle,
  output logic        out_valid,
  output logic [1:0]  out_reply_kind,
  output logic [2:0]  out_slot,
  output logic [15:0] out_handle,
  output logic        out_status,
  output logic        out_is_last
);
  import ttsd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ttsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  ttsd_dpath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_command     (in_command),
    .in_slot_id     (in_slot_id),
    .in_task_handle (in_task_handle),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_reply_kind (out_reply_kind),
    .out_slot       (out_slot),
    .out_handle     (out_handle),
    .out_status     (out_status),
    .out_is_last    (out_is_last)
  );

endmodule

FILE: hdl/ttsd_ctrl.sv
// Tick task slot dispatcher: sequencing state machine.
// Depends on ttsd_pkg for states and the command/status bundles.
module ttsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_command,
  input  ttsd_pkg::dp_sts_t   sts,
  output ttsd_pkg::ctrl_cmd_t cmd,
  output logic                busy
);
  import ttsd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (in_command)
            CMD_REGISTER:   state_nxt = S_REG;
            CMD_ENABLE:     state_nxt = S_MOD;
            CMD_DISABLE:    state_nxt = S_MOD;
            CMD_UNREGISTER: state_nxt = S_MOD;
            CMD_TICK:       state_nxt = S_TICK;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_REG: begin
        if (sts.handle_zero || sts.idx_end) begin
          cmd.reg_fail = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.reg_write = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.reg_advance = 1'b1;
        end
      end
      S_MOD: begin
        cmd.mod_apply = 1'b1;
        state_nxt     = sts.unreg_top ? S_TRIM : S_IDLE;
      end
      S_TRIM: begin
        if (sts.trim_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.trim_step = 1'b1;
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.tick_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ttsd_dpath.sv
// Tick task slot dispatcher: slot table, scan pointer, scan limit,
// handle memory and result register. Depends on ttsd_pkg.
module ttsd_dpath #(
  parameter int SLOT_COUNT  = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ttsd_pkg::ctrl_cmd_t cmd,
  input  logic [2:0]          in_command,
  input  logic [3:0]          in_slot_id,
  input  logic [15:0]         in_task_handle,
  output ttsd_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output logic [1:0]          out_reply_kind,
  output logic [2:0]          out_slot,
  output logic [15:0]         out_handle,
  output logic                out_status,
  output logic                out_is_last
);
  import ttsd_pkg::*;

  localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [HW-1:0]         mem [SLOT_COUNT];
  logic [HW-1:0]         rdata_r;

  logic [SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [SLOT_COUNT-1:0] en_r, en_nxt;
  logic [CW-1:0]         limit_r, limit_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [2:0]            opc_r;
  logic [3:0]            sid_r;
  logic [HW-1:0]         hnd_r;

  logic                  rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]         rd_slot_r;
  logic                  hold_vld_r, hold_vld_nxt;
  logic [IW-1:0]         hold_slot_r;
  logic [HW-1:0]         hold_hnd_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [2:0]            out_slot_r, out_slot_nxt;
  logic [15:0]           out_hnd_r, out_hnd_nxt;
  logic                  out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [7:0]            sid_w;
  logic                  sid_in;
  logic [IW-1:0]         six, ix, lim_ix;
  logic [CW-1:0]         lim_m1;
  logic                  scan_active, hit, rd_en, wr_en;

  assign sid_w       = 8'(sid_r);
  assign sid_in      = sid_w < 8'(SLOT_COUNT);
  assign six         = sid_w[IW-1:0];
  assign ix          = idx_r[IW-1:0];
  assign lim_m1      = limit_r - 1'b1;
  assign lim_ix      = lim_m1[IW-1:0];
  assign scan_active = (idx_r < limit_r) && (cnt_r < MAX_DISPATCH);
  assign hit         = scan_active && occ_r[ix] && en_r[ix];
  assign rd_en       = cmd.tick_step && hit;
  assign wr_en       = cmd.reg_write;

  always_comb begin
    sts.handle_zero = (hnd_r == '0);
    sts.idx_end     = (idx_r == CW'(SLOT_COUNT));
    sts.slot_free   = !occ_r[ix];
    sts.unreg_top   = (opc_r == CMD_UNREGISTER) && sid_in
                      && ((sid_w + 8'd1) == 8'(limit_r));
    sts.trim_done   = (limit_r == '0) || occ_r[lim_ix];
    sts.tick_done   = !scan_active && !rd_vld_r && !hold_vld_r;
  end

  always_comb begin
    occ_nxt        = occ_r;
    en_nxt         = en_r;
    limit_nxt      = limit_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    hold_vld_nxt   = hold_vld_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = RK_REGISTER;
    out_slot_nxt   = '0;
    out_hnd_nxt    = '0;
    out_status_nxt = 1'b0;
    out_last_nxt   = 1'b0;

    if (cmd.load) begin
      idx_nxt      = '0;
      cnt_nxt      = '0;
      hold_vld_nxt = 1'b0;
    end

    if (cmd.reg_fail) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = RK_REGISTER;
      out_status_nxt = 1'b1;
      out_last_nxt   = 1'b1;
    end

    if (cmd.reg_write) begin
      occ_nxt[ix]   = 1'b1;
      en_nxt[ix]    = 1'b1;
      if (idx_r >= limit_r) begin
        limit_nxt = idx_r + 1'b1;
      end
      out_valid_nxt = 1'b1;
      out_kind_nxt  = RK_REGISTER;
      out_slot_nxt  = 3'(ix);
      out_last_nxt  = 1'b1;
    end

    if (cmd.reg_advance) begin
      idx_nxt = idx_r + 1'b1;
    end

    if (cmd.mod_apply) begin
      if (sid_in) begin
        case (opc_r)
          CMD_ENABLE: begin
            if (occ_r[six]) begin
              en_nxt[six] = 1'b1;
            end
          end
          CMD_DISABLE: begin
            en_nxt[six] = 1'b0;
          end
          CMD_UNREGISTER: begin
            occ_nxt[six] = 1'b0;
            en_nxt[six]  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      out_valid_nxt = 1'b1;
      out_kind_nxt  = RK_ACK;
      out_last_nxt  = 1'b1;
    end

    if (cmd.trim_step) begin
      limit_nxt = lim_m1;
    end

    if (cmd.tick_step) begin
      if (scan_active) begin
        idx_nxt = idx_r + 1'b1;
      end
      if (hit) begin
        rd_vld_nxt = 1'b1;
        cnt_nxt    = cnt_r + 4'd1;
      end
      if (rd_vld_r) begin
        if (hold_vld_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RK_DISPATCH;
          out_slot_nxt  = 3'(hold_slot_r);
          out_hnd_nxt   = 16'(hold_hnd_r);
        end
        hold_vld_nxt = 1'b1;
      end else if (!scan_active && hold_vld_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = RK_DISPATCH;
        out_slot_nxt  = 3'(hold_slot_r);
        out_hnd_nxt   = 16'(hold_hnd_r);
        out_last_nxt  = 1'b1;
        hold_vld_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ix] <= hnd_r;
    end
    if (rd_en) begin
      rdata_r <= mem[ix];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      en_r        <= '0;
      limit_r     <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      en_r        <= en_nxt;
      limit_r     <= limit_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opc_r <= in_command;
      sid_r <= in_slot_id;
      hnd_r <= in_task_handle[HW-1:0];
    end
    if (rd_en) begin
      rd_slot_r <= ix;
    end
    if (cmd.tick_step && rd_vld_r) begin
      hold_slot_r <= rd_slot_r;
      hold_hnd_r  <= rdata_r;
    end
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hnd_r    <= out_hnd_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = out_kind_r;
  assign out_slot       = out_slot_r;
  assign out_handle     = out_hnd_r;
  assign out_status     = out_status_r;
  assign out_is_last    = out_last_r;

  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    limit_r <= CW'(SLOT_COUNT))
    else $error("scan limit beyond slot count");

  a_enable_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (en_r & ~occ_r) == '0)
    else $error("enable bit set on empty slot");

  a_dispatch_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_DISPATCH)
    else $error("dispatch count overrun");

  a_dispatch_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == RK_DISPATCH) |-> out_hnd_r != '0)
    else $error("dispatch of empty handle");

  a_limit_top_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (limit_r != '0) && !cmd.trim_step && !sts.unreg_top && !cmd.mod_apply
      |-> occ_r[lim_ix] || $past(cmd.mod_apply))
    else $error("scan limit top slot empty");

endmodule

FILE: sim/tb_tick_task_slot_dispatcher.sv
`timescale 1ns / 1ps
// Testbench for tick_task_slot_dispatcher: directed and random slot requests,
// each result checked against an in-bench slot table model.
// Depends on ttsd_pkg and the tick_task_slot_dispatcher RTL.
module tb_tick_task_slot_dispatcher;
  import ttsd_pkg::*;

  localparam int          SLOT_COUNT       = 8;
  localparam int          DRAIN_CYCLES     = SLOT_COUNT + 8;
  localparam logic [2:0]  UNUSED_CMD_FIRST = 3'd5;
  localparam logic [2:0]  UNUSED_CMD_LAST  = 3'd7;

  typedef struct {
    reply_kind_t kind;
    logic [2:0]  slot;
    logic [15:0] handle;
    logic        status;
    logic        last;
  } slot_reply_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [2:0]  in_command     = '0;
  logic [3:0]  in_slot_id     = '0;
  logic [15:0] in_task_handle = '0;
  logic        out_valid;
  logic [1:0]  out_reply_kind;
  logic [2:0]  out_slot;
  logic [15:0] out_handle;
  logic        out_status;
  logic        out_is_last;

  logic [15:0] slot_handle [SLOT_COUNT];
  logic        slot_enabled [SLOT_COUNT];
  int unsigned scan_top;
  slot_reply_t pending_replies [$];
  int          error_count = 0;
  bit          no_idle     = 1'b0;

  tick_task_slot_dispatcher u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_slot_id     (in_slot_id),
    .in_task_handle (in_task_handle),
    .out_valid      (out_valid),
    .out_reply_kind (out_reply_kind),
    .out_slot       (out_slot),
    .out_handle     (out_handle),
    .out_status     (out_status),
    .out_is_last    (out_is_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void predict_request(input logic [2:0] cmd, input logic [3:0] sid,
                                          input logic [15:0] hnd);
    slot_reply_t batch [$];
    slot_reply_t r;
    bit          placed;
    r.kind   = RK_ACK;
    r.slot   = '0;
    r.handle = '0;
    r.status = 1'b0;
    r.last   = 1'b1;
    placed   = 1'b0;
    case (cmd)
      CMD_REGISTER: begin
        r.kind   = RK_REGISTER;
        r.status = 1'b1;
        if (hnd != '0) begin
          for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
            if (slot_handle[i] == '0) begin
              slot_handle[i]  = hnd;
              slot_enabled[i] = 1'b1;
              if (i >= scan_top) scan_top = i + 1;
              r.slot   = i[2:0];
              r.status = 1'b0;
              placed   = 1'b1;
            end
          end
        end
        pending_replies.push_back(r);
      end
      CMD_ENABLE, CMD_DISABLE, CMD_UNREGISTER: begin
        if (sid < SLOT_COUNT) begin
          if (cmd == CMD_ENABLE) begin
            if (slot_handle[sid] != '0) slot_enabled[sid] = 1'b1;
          end else if (cmd == CMD_DISABLE) begin
            slot_enabled[sid] = 1'b0;
          end else begin
            slot_handle[sid]  = '0;
            slot_enabled[sid] = 1'b0;
            if (sid + 1 == scan_top) begin
              while (scan_top > 0 && slot_handle[scan_top - 1] == '0) scan_top--;
            end
          end
        end
        pending_replies.push_back(r);
      end
      CMD_TICK: begin
        for (int i = 0; i < scan_top && i < SLOT_COUNT && batch.size() < 8; i++) begin
          if (slot_handle[i] != '0 && slot_enabled[i]) begin
            r.kind   = RK_DISPATCH;
            r.slot   = i[2:0];
            r.handle = slot_handle[i];
            r.last   = 1'b0;
            batch.push_back(r);
          end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) pending_replies.push_back(batch[k]);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    slot_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d slot %0d handle %0h",
                 $time, out_reply_kind, out_slot, out_handle);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("reply_kind", want.kind, out_reply_kind);
        check_field("slot", want.slot, out_slot);
        check_field("handle", want.handle, out_handle);
        check_field("status", want.status, out_status);
        check_field("is_last", want.last, out_is_last);
      end
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [3:0] sid,
                              input logic [15:0] hnd);
    int unsigned gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_slot_id     <= sid;
    in_task_handle <= hnd;
    do @(posedge clk); while (busy);
    predict_request(cmd, sid, hnd);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_and_invalid();
    send_request(CMD_TICK, 4'd0, 16'h0000);
    send_request(CMD_REGISTER, 4'd0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_fill_and_dispatch();
    logic [15:0] fill [SLOT_COUNT] = '{16'hFFFF, 16'h0001, 16'hA5A5, 16'h5A5A,
                                       16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00};
    foreach (fill[i]) send_request(CMD_REGISTER, 4'd0, fill[i]);
    // table is full now
    send_request(CMD_REGISTER, 4'd0, 16'h1234);
    send_request(CMD_TICK, 4'd0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_slot_commands();
    send_request(CMD_DISABLE, 4'd3, 16'h0000);
    send_request(CMD_UNREGISTER, 4'd5, 16'h0000);
    send_request(CMD_UNREGISTER, 4'd6, 16'h0000);
    // drop the top slot and trim past the empties below it
    send_request(CMD_UNREGISTER, 4'd7, 16'h0000);
    send_request(CMD_TICK, 4'd0, 16'h0000);
    send_request(CMD_ENABLE, 4'd6, 16'h0000);
    send_request(CMD_ENABLE, 4'd3, 16'h0000);
    send_request(CMD_DISABLE, 4'd15, 16'h0000);
    send_request(CMD_UNREGISTER, 4'd8, 16'h0000);
    wait_drained();
  endtask

  task automatic test_unknown_commands();
    for (logic [3:0] c = UNUSED_CMD_FIRST; c <= UNUSED_CMD_LAST; c++) begin
      send_request(c[2:0], 4'hF, 16'hFFFF);
    end
    send_request(CMD_TICK, 4'd0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  cmd;
    logic [3:0]  sid;
    logic [15:0] hnd;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      sid  = ($urandom_range(99) < 80) ? 4'($urandom_range(SLOT_COUNT - 1))
                                       : 4'($urandom_range(15));
      hnd  = ($urandom_range(99) < 5) ? 16'h0000 : 16'($urandom);
      if (pick < 30)      cmd = CMD_REGISTER;
      else if (pick < 42) cmd = CMD_ENABLE;
      else if (pick < 54) cmd = CMD_DISABLE;
      else if (pick < 73) cmd = CMD_UNREGISTER;
      else if (pick < 97) cmd = CMD_TICK;
      else                cmd = 3'($urandom_range(UNUSED_CMD_LAST, UNUSED_CMD_FIRST));
      send_request(cmd, sid, hnd);
      if (cmd <= CMD_TICK) sent++;
    end
    wait_drained();
  endtask

  task automatic test_burst_no_idle();
    no_idle = 1'b1;
    test_random_traffic(30);
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (slot_handle[i]) begin
      slot_handle[i]  = '0;
      slot_enabled[i] = 1'b0;
    end
    scan_top = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_invalid();
    test_fill_and_dispatch();
    test_slot_commands();
    test_unknown_commands();
    test_random_traffic(85);
    test_burst_no_idle();
    test_random_traffic(85);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/ttsd_pkg.sv
hdl/ttsd_ctrl.sv
hdl/ttsd_dpath.sv
hdl/tick_task_slot_dispatcher.sv
sim/tb_tick_task_slot_dispatcher.sv
